@@ design/mhpq_pkg.sv @@
`default_nettype none

package mhpq_pkg;

   // Default number of heap slots.
   localparam int DEFAULT_CAPACITY = 64;

   localparam int KEY_W = 32;

   // Request function codes. Any other code is handled as a peek.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_PEEK   = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_LOAD,
      ST_KEY,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ design/mhpq_ram.sv @@
`default_nettype none

// Heap storage: one write port and two read ports, read data registered.
module mhpq_ram #(
   parameter int DEPTH = mhpq_pkg::DEFAULT_CAPACITY,
   parameter int WIDTH = mhpq_pkg::KEY_W,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr_a,
   input  wire logic [AddrW-1:0] rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

@@ design/max_heap_priority_queue.sv @@
// Sequence: a peek, a failed request or removing the last key goes straight to the result;
// an insert sifts the new key up, a remove fetches the last key and sifts it down from the
// root, level by level (a level is a read, then a compare and write). Throughput: one
// request at a time; the next is taken once the result is in the output register, where it
// may wait for rsp_ready.
// Reset: synchronous, active high; it empties the heap, the memory itself is not cleared.
`default_nettype none

module max_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_key_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_top_key,
   output logic                    rsp_top_valid,
   output logic [6:0]              rsp_entry_count,
   output logic [1:0]              rsp_status
);

   // Slot addresses and the live count (which must be able to hold CAPACITY itself).
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   // Child indices can reach twice the capacity, so they get two extra bits.
   localparam int IW = AW + 2;

   mhpq_pkg::state_type state_ff, state_in;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [31:0] key_ff, key_in;
   logic signed [31:0] top_ff, top_in;
   logic [1:0]         status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_top_key_ff, rsp_top_key_in;
   logic               rsp_top_valid_ff, rsp_top_valid_in;
   logic [6:0]         rsp_entry_count_ff, rsp_entry_count_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   // Memory port signals.
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [AW-1:0]      rd_addr_a;
   logic [AW-1:0]      rd_addr_b;
   logic [31:0]        rd_data_a;
   logic [31:0]        rd_data_b;

   logic               req_fire;
   logic [AW-1:0]      parent;
   logic [IW-1:0]      left_idx;
   logic [IW-1:0]      right_idx;
   logic [IW-1:0]      cnt_wide;
   logic [CW+6:0]      cnt_ext;
   logic signed [31:0] cur_key;
   logic signed [31:0] child_a;
   logic signed [31:0] child_b;
   logic               take_right;
   logic signed [31:0] big_key;
   logic [AW-1:0]      big_idx;

   mhpq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (32)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // A new request is taken whenever the sequencer is idle; the output register
   // decouples this from the response side.
   assign req_ready = (state_ff == mhpq_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Index arithmetic for the current hole position.
   assign parent    = (pos_ff - AW'(1)) >> 1;
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + IW'(1);
   assign cnt_wide  = {{(IW - CW){1'b0}}, cnt_ff};
   assign cnt_ext   = {7'd0, cnt_ff};

   // The key being sifted lives in a register; in the first sift-down step it is
   // still on its way out of the memory.
   assign cur_key = (state_ff == mhpq_pkg::ST_KEY) ? $signed(rd_data_a) : key_ff;

   // Pick the larger live child; the left one wins a tie.
   assign child_a    = $signed(rd_data_a);
   assign child_b    = $signed(rd_data_b);
   assign take_right = (right_idx < cnt_wide) && (child_a < child_b);
   assign big_key    = take_right ? child_b : child_a;
   assign big_idx    = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff             <= pos_in;
      key_ff             <= key_in;
      top_ff             <= top_in;
      status_ff          <= status_in;
      rsp_top_key_ff     <= rsp_top_key_in;
      rsp_top_valid_ff   <= rsp_top_valid_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_status_ff      <= rsp_status_in;
   end

   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      pos_in             = pos_ff;
      key_in             = key_ff;
      status_in          = status_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_top_key_in     = rsp_top_key_ff;
      rsp_top_valid_in   = rsp_top_valid_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_status_in      = rsp_status_ff;
      wr_en              = 1'b0;
      wr_addr            = pos_ff;
      wr_data            = cur_key;
      rd_addr_a          = parent;
      rd_addr_b          = right_idx[AW-1:0];

      case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (req_fire) begin
               status_in = mhpq_pkg::STATUS_OK;
               state_in  = mhpq_pkg::ST_DONE;
               case (req_func)
                  mhpq_pkg::FUNC_INSERT: begin
                     if (cnt_ff >= CW'(CAPACITY)) begin
                        status_in = mhpq_pkg::STATUS_OVERFLOW;
                     end else begin
                        // The new key starts in the first free slot.
                        key_in   = req_key_in;
                        pos_in   = cnt_ff[AW-1:0];
                        cnt_in   = cnt_ff + CW'(1);
                        state_in = mhpq_pkg::ST_UP_RD;
                     end
                  end
                  mhpq_pkg::FUNC_REMOVE: begin
                     if (cnt_ff == '0) begin
                        status_in = mhpq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        // Unless it was the only one, the last entry is fetched and sifted down from the root.
                        cnt_in = cnt_ff - CW'(1);
                        pos_in = '0;
                        if (cnt_ff != CW'(1)) begin
                           state_in = mhpq_pkg::ST_LOAD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         mhpq_pkg::ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = mhpq_pkg::ST_DONE;
            end else begin
               state_in = mhpq_pkg::ST_UP_CMP;
            end
         end

         mhpq_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (child_a < key_ff) begin
               // The parent moves down into the hole and the hole moves up.
               wr_data  = child_a;
               pos_in   = parent;
               state_in = mhpq_pkg::ST_UP_RD;
            end else begin
               state_in = mhpq_pkg::ST_DONE;
            end
         end

         mhpq_pkg::ST_LOAD: begin
            rd_addr_a = cnt_ff[AW-1:0];
            state_in  = mhpq_pkg::ST_KEY;
         end

         mhpq_pkg::ST_KEY, mhpq_pkg::ST_DN_RD: begin
            key_in    = cur_key;
            rd_addr_a = left_idx[AW-1:0];
            if (left_idx >= cnt_wide) begin
               wr_en    = 1'b1;
               state_in = mhpq_pkg::ST_DONE;
            end else begin
               state_in = mhpq_pkg::ST_DN_CMP;
            end
         end

         mhpq_pkg::ST_DN_CMP: begin
            wr_en = 1'b1;
            if (key_ff < big_key) begin
               // The larger child moves up into the hole and the hole moves down.
               wr_data  = big_key;
               pos_in   = big_idx;
               state_in = mhpq_pkg::ST_DN_RD;
            end else begin
               state_in = mhpq_pkg::ST_DONE;
            end
         end

         mhpq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_top_valid_in   = (cnt_ff != '0);
               rsp_top_key_in     = (cnt_ff != '0) ? top_ff : 32'sd0;
               rsp_entry_count_in = cnt_ext[6:0];
               rsp_status_in      = status_ff;
               state_in           = mhpq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   // The root is shadowed in a register so the result never needs a memory read.
   assign top_in = (wr_en && (wr_addr == '0)) ? wr_data : top_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_key     = rsp_top_key_ff;
   assign rsp_top_valid   = rsp_top_valid_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

   // The count never exceeds the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
   else $error("heap count exceeds capacity");

   // While comparing, the hole always lies inside the live part of the heap.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mhpq_pkg::ST_UP_CMP || state_ff == mhpq_pkg::ST_DN_CMP)
      |-> ({{(IW - AW){1'b0}}, pos_ff} < cnt_wide))
   else $error("sift position outside live entries");

   // The memory is written only while a sift is in progress.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != mhpq_pkg::ST_IDLE && state_ff != mhpq_pkg::ST_DONE
                 && state_ff != mhpq_pkg::ST_LOAD))
   else $error("heap memory written outside a sift");

   // An accepted request always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != mhpq_pkg::ST_IDLE))
   else $error("accepted request did not start");

   // A sift-down child compare only follows a read of the children.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mhpq_pkg::ST_DN_CMP)
      |-> ($past(state_ff) == mhpq_pkg::ST_DN_RD || $past(state_ff) == mhpq_pkg::ST_KEY))
   else $error("child compare without child read");

endmodule

`default_nettype wire
